// ===== rtl/frx_pkg.sv =====
// ----------------------------------------------------------------------------
// frx_pkg
// Types, codes and the CRC-32 byte step shared by the frame receiver.
// ----------------------------------------------------------------------------
package frx_pkg;

    typedef struct packed {
        logic        command;
        logic [7:0]  data_byte;
        logic [31:0] now_ms;
        logic [9:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  frame_command;
        logic [15:0] sequence_number;
        logic [10:0] data_length;
        logic [7:0]  read_byte;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] value;
    } t_cfg_item;

    localparam logic [2:0] CFG_START_FIRST  = 3'd0;
    localparam logic [2:0] CFG_START_SECOND = 3'd1;
    localparam logic [2:0] CFG_VERSION      = 3'd2;
    localparam logic [2:0] CFG_TIMEOUT      = 3'd3;
    localparam logic [2:0] CFG_MAX_LEN      = 3'd4;

    localparam logic [2:0] ST_MORE    = 3'd0;
    localparam logic [2:0] ST_PACKET  = 3'd1;
    localparam logic [2:0] ST_TIMEOUT = 3'd2;
    localparam logic [2:0] ST_BADCRC  = 3'd3;
    localparam logic [2:0] ST_BADLEN  = 3'd4;

    localparam logic        CMD_CONSUME = 1'b0;
    localparam logic        CMD_READ    = 1'b1;

    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
    localparam logic [31:0] TIMEOUT_RESET   = 32'd1000;
    localparam logic [10:0] MAX_LEN_RESET   = 11'd1024;

    typedef enum logic [4:0] {
        PH_FIRST   = 5'b00001,
        PH_SECOND  = 5'b00010,
        PH_HEADER  = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_CRC     = 5'b10000
    } t_phase;

    // reflected CRC-32, one byte; flattens to an xor network
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/frx_chan_if.sv =====
// ----------------------------------------------------------------------------
// frx_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface frx_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/frx_payload_mem.sv =====
// ----------------------------------------------------------------------------
// frx_payload_mem
// Payload byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module frx_payload_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [0:DEPTH-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/frame_receiver_crc32_timeout_top.sv =====
// ----------------------------------------------------------------------------
// frame_receiver_crc32_timeout_top
// Byte-wise frame receiver: start bytes, header, payload into memory,
// CRC-32 check, inter-byte timeout, payload read-back by index.
//
//  channel | dir | payload
//  --------+-----+-----------------------------------------------------
//  i_in    | in  | command, data_byte, now_ms, read_index
//  o_out   | out | status, frame_command, sequence_number,
//          |     | data_length, read_byte
//  i_cfg   | in  | index, value (register write, always ready)
//
// One item per cycle while the output drains; its result is in the output
// register in the cycle after the transfer, read byte from the registered read port.
// Input is taken whenever the output register is empty or drains that cycle.
// Synchronous active-low reset; the payload memory needs no clearing pass.
// ----------------------------------------------------------------------------
module frame_receiver_crc32_timeout_top #(
    parameter int PAYLOAD_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    frx_chan_if.sink    i_in,
    frx_chan_if.source  o_out,
    frx_chan_if.sink    i_cfg
);
    import frx_pkg::*;

    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    // configuration
    logic [7:0]  r_start_first;
    logic [7:0]  r_start_second;
    logic [7:0]  r_version;
    logic [31:0] r_timeout;
    logic [10:0] r_max_len;

    // parser state
    t_phase      r_phase, n_phase;
    logic [10:0] r_pos, n_pos;
    logic [31:0] r_last, n_last;
    logic [31:0] r_crc, n_crc;
    logic [10:0] r_flen, n_flen;
    logic [7:0]  r_hdr   [0:4];
    logic [7:0]  r_crcb  [0:2];

    // output register
    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [7:0]  r_fcmd;
    logic [15:0] r_seq;
    logic [10:0] r_olen;
    logic        r_rd_hit;

    t_in_item    item;
    t_cfg_item   cfg;
    logic        in_fire, cfg_fire;
    logic [31:0] gap;
    logic        timed_out;
    t_phase      restart_phase;
    logic [10:0] pos_inc;
    logic [15:0] hdr_len;
    logic        len_bad;
    logic [31:0] crc_got;
    logic        pay_in_range, rd_in_range;
    logic [2:0]  n_status;
    logic [7:0]  n_fcmd;
    logic [15:0] n_seq;
    logic [10:0] n_olen;
    logic        hdr_we, crcb_we, pay_we;
    logic        mem_we, mem_re;
    logic [7:0]  mem_rdata;

    assign item     = i_in.data;
    assign cfg      = i_cfg.data;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign in_fire  = i_in.valid && i_in.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;

    assign gap           = item.now_ms - r_last;
    assign timed_out     = (r_phase != PH_FIRST) && (gap > r_timeout);
    assign restart_phase = (item.data_byte == r_start_first) ? PH_SECOND : PH_FIRST;
    assign pos_inc       = r_pos + 11'd1;
    assign hdr_len       = {item.data_byte, r_hdr[4]};
    assign len_bad       = (hdr_len > {5'd0, r_max_len}) ||
                           (17'(hdr_len) > 17'(PAYLOAD_DEPTH));
    assign crc_got       = {item.data_byte, r_crcb[2], r_crcb[1], r_crcb[0]};
    assign pay_in_range  = 17'(r_pos) < 17'(PAYLOAD_DEPTH);
    assign rd_in_range   = 17'(item.read_index) < 17'(PAYLOAD_DEPTH);

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_last   = r_last;
        n_crc    = r_crc;
        n_flen   = r_flen;
        n_status = ST_MORE;
        n_fcmd   = 8'd0;
        n_seq    = 16'd0;
        n_olen   = 11'd0;
        hdr_we   = 1'b0;
        crcb_we  = 1'b0;
        pay_we   = 1'b0;
        if (item.command == CMD_CONSUME) begin
            n_last = item.now_ms;
            if (timed_out) begin
                n_phase  = restart_phase;
                n_pos    = 11'd0;
                n_status = ST_TIMEOUT;
            end else begin
                case (r_phase)
                    PH_FIRST: begin
                        if (item.data_byte == r_start_first) begin
                            n_phase = PH_SECOND;
                        end
                    end
                    PH_SECOND: begin
                        n_pos = 11'd0;
                        if (item.data_byte == r_start_second) begin
                            n_phase = PH_HEADER;
                            n_crc   = CRC_INIT;
                        end else begin
                            n_phase = restart_phase;
                        end
                    end
                    PH_HEADER: begin
                        hdr_we = 1'b1;
                        n_pos  = pos_inc;
                        n_crc  = crc32_byte(r_crc, item.data_byte);
                        if (r_pos[2:0] == 3'd5) begin
                            n_pos = 11'd0;
                            if (len_bad) begin
                                n_phase  = restart_phase;
                                n_status = ST_BADLEN;
                            end else begin
                                n_flen  = hdr_len[10:0];
                                n_phase = (hdr_len == 16'd0) ? PH_CRC : PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        pay_we = pay_in_range;
                        n_crc  = crc32_byte(r_crc, item.data_byte);
                        n_pos  = pos_inc;
                        if (pos_inc >= r_flen) begin
                            n_pos   = 11'd0;
                            n_phase = PH_CRC;
                        end
                    end
                    PH_CRC: begin
                        crcb_we = 1'b1;
                        n_pos   = pos_inc;
                        if (r_pos[1:0] == 2'd3) begin
                            n_pos   = 11'd0;
                            n_phase = restart_phase;
                            if ((r_hdr[0] != r_version) || (crc_got != ~r_crc)) begin
                                n_status = ST_BADCRC;
                            end else begin
                                n_status = ST_PACKET;
                                n_fcmd   = r_hdr[1];
                                n_seq    = {r_hdr[3], r_hdr[2]};
                                n_olen   = r_flen;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_FIRST;
                        n_pos   = 11'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_first  <= 8'd0;
            r_start_second <= 8'd0;
            r_version      <= 8'd0;
            r_timeout      <= TIMEOUT_RESET;
            r_max_len      <= MAX_LEN_RESET;
        end else if (cfg_fire) begin
            case (cfg.index)
                CFG_START_FIRST:  r_start_first  <= cfg.value[7:0];
                CFG_START_SECOND: r_start_second <= cfg.value[7:0];
                CFG_VERSION:      r_version      <= cfg.value[7:0];
                CFG_TIMEOUT:      r_timeout      <= cfg.value;
                CFG_MAX_LEN:      r_max_len      <= cfg.value[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_pos   <= 11'd0;
            r_last  <= 32'd0;
            r_crc   <= 32'd0;
            r_flen  <= 11'd0;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_last  <= n_last;
            r_crc   <= n_crc;
            r_flen  <= n_flen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && hdr_we && (r_pos[2:0] != 3'd5)) begin
            r_hdr[r_pos[2:0]] <= item.data_byte;
        end
        if (in_fire && crcb_we && (r_pos[1:0] != 2'd3)) begin
            r_crcb[r_pos[1:0]] <= item.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status <= n_status;
            r_fcmd   <= n_fcmd;
            r_seq    <= n_seq;
            r_olen   <= n_olen;
            r_rd_hit <= mem_re;
        end
    end

    assign mem_we = in_fire && pay_we;
    assign mem_re = in_fire && (item.command == CMD_READ) && rd_in_range;

    frx_payload_mem #(
        .DEPTH (PAYLOAD_DEPTH),
        .AW    (AW)
    ) u_payload_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(r_pos)),
        .i_wdata (item.data_byte),
        .i_re    (mem_re),
        .i_raddr (AW'(item.read_index)),
        .o_rdata (mem_rdata)
    );

    assign o_out.valid                = r_out_valid;
    assign o_out.data.status          = r_status;
    assign o_out.data.frame_command   = r_fcmd;
    assign o_out.data.sequence_number = r_seq;
    assign o_out.data.data_length     = r_olen;
    assign o_out.data.read_byte       = r_rd_hit ? mem_rdata : 8'd0;
endmodule

// ===== verif/frx_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frx_frame_checker
// Watches the byte, result and register channels of the frame receiver.
// Keeps its own copy of the deframer state, works out the result of every
// input transfer and compares each result transfer with the oldest one.
// ----------------------------------------------------------------------------
module frx_frame_checker
    import frx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  t_cfg_item i_cfg_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_result_count,
    output int        o_packet_count
);

    localparam int MEM_DEPTH = 1024;

    logic [7:0]  sof1_r;
    logic [7:0]  sof2_r;
    logic [7:0]  ver_r;
    logic [31:0] tmo_r;
    logic [10:0] maxlen_r;

    t_phase      rx_phase;
    logic [10:0] rx_pos;
    logic [7:0]  hdr_q [6];
    logic [31:0] last_ms;
    logic [31:0] crc_acc;
    logic [7:0]  crc_rx [4];
    logic [7:0]  pay_mem [MEM_DEPTH];
    logic [10:0] frame_len;

    t_out_item   expected_results [$];

    function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        repeat (8) c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        return c;
    endfunction

    function automatic void hunt_from(input logic [7:0] b);
        if (b == sof1_r) begin
            rx_phase = PH_SECOND;
        end else begin
            rx_phase = PH_FIRST;
        end
        rx_pos = '0;
    endfunction

    function automatic t_out_item frame_step(input t_in_item it);
        t_out_item   r;
        logic [31:0] gap;
        logic [15:0] len;
        logic [31:0] rx_crc;
        r   = '0;
        gap = it.now_ms - last_ms;
        if (it.command == CMD_READ) begin
            r.read_byte = pay_mem[it.read_index];
        end else if (rx_phase != PH_FIRST && gap > tmo_r) begin
            hunt_from(it.data_byte);
            last_ms  = it.now_ms;
            r.status = ST_TIMEOUT;
        end else begin
            last_ms = it.now_ms;
            case (rx_phase)
                PH_FIRST: begin
                    if (it.data_byte == sof1_r) rx_phase = PH_SECOND;
                end
                PH_SECOND: begin
                    if (it.data_byte == sof2_r) begin
                        rx_phase = PH_HEADER;
                        rx_pos   = '0;
                    end else begin
                        hunt_from(it.data_byte);
                    end
                end
                PH_HEADER: begin
                    hdr_q[3'(rx_pos % 11'd6)] = it.data_byte;
                    rx_pos++;
                    if (rx_pos >= 11'd6) begin
                        len = {hdr_q[5], hdr_q[4]};
                        if (len > maxlen_r || len > MEM_DEPTH) begin
                            hunt_from(it.data_byte);
                            r.status = ST_BADLEN;
                        end else begin
                            frame_len = len[10:0];
                            crc_acc   = CRC_INIT;
                            for (int k = 0; k < 6; k++) crc_acc = crc32_update(crc_acc, hdr_q[k]);
                            rx_pos = '0;
                            if (len == 16'd0) begin
                                rx_phase = PH_CRC;
                            end else begin
                                rx_phase = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (rx_pos < MEM_DEPTH) pay_mem[rx_pos[9:0]] = it.data_byte;
                    crc_acc = crc32_update(crc_acc, it.data_byte);
                    rx_pos++;
                    if (rx_pos >= frame_len) begin
                        rx_pos   = '0;
                        rx_phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    crc_rx[rx_pos[1:0]] = it.data_byte;
                    rx_pos++;
                    if (rx_pos >= 11'd4) begin
                        rx_crc = {crc_rx[3], crc_rx[2], crc_rx[1], crc_rx[0]};
                        hunt_from(it.data_byte);
                        if (hdr_q[0] != ver_r || (crc_acc ^ 32'hFFFF_FFFF) != rx_crc) begin
                            r.status = ST_BADCRC;
                        end else begin
                            r.status          = ST_PACKET;
                            r.frame_command   = hdr_q[1];
                            r.sequence_number = {hdr_q[3], hdr_q[2]};
                            r.data_length     = frame_len;
                        end
                    end
                end
                default: begin
                    rx_phase = PH_FIRST;
                    rx_pos   = '0;
                end
            endcase
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item e;
        t_out_item a;
        if (!i_rst_n) begin
            sof1_r         = '0;
            sof2_r         = '0;
            ver_r          = '0;
            tmo_r          = TIMEOUT_RESET;
            maxlen_r       = MAX_LEN_RESET;
            rx_phase       = PH_FIRST;
            rx_pos         = '0;
            last_ms        = '0;
            crc_acc        = '0;
            frame_len      = '0;
            expected_results.delete();
            o_fail_count   = 0;
            o_result_count = 0;
            o_packet_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                a = i_out_data;
                o_result_count++;
                if (expected_results.size() == 0) begin
                    $error("result transfer with no input pending, status %0d", a.status);
                    o_fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (e.status == ST_PACKET) o_packet_count++;
                    if (a.status !== e.status) begin
                        $error("status: expected %0d, actual %0d", e.status, a.status);
                        o_fail_count++;
                    end
                    if (a.frame_command !== e.frame_command) begin
                        $error("frame_command: expected %0d, actual %0d",
                               e.frame_command, a.frame_command);
                        o_fail_count++;
                    end
                    if (a.sequence_number !== e.sequence_number) begin
                        $error("sequence_number: expected %0d, actual %0d",
                               e.sequence_number, a.sequence_number);
                        o_fail_count++;
                    end
                    if (a.data_length !== e.data_length) begin
                        $error("data_length: expected %0d, actual %0d",
                               e.data_length, a.data_length);
                        o_fail_count++;
                    end
                    if (a.read_byte !== e.read_byte) begin
                        $error("read_byte: expected %0d, actual %0d", e.read_byte, a.read_byte);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.index)
                    CFG_START_FIRST:  sof1_r   = i_cfg_data.value[7:0];
                    CFG_START_SECOND: sof2_r   = i_cfg_data.value[7:0];
                    CFG_VERSION:      ver_r    = i_cfg_data.value[7:0];
                    CFG_TIMEOUT:      tmo_r    = i_cfg_data.value;
                    CFG_MAX_LEN:      maxlen_r = i_cfg_data.value[10:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) expected_results.push_back(frame_step(i_in_data));
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== verif/tb_frame_receiver_crc32_timeout_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_receiver_crc32_timeout_top
// Drives framed byte streams into the frame receiver: good frames, bad CRC,
// wrong version, oversize length, inter-byte timeouts, line noise and payload
// reads, over several register settings and back-pressure patterns. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_frame_receiver_crc32_timeout_top;
    import frx_pkg::*;

    typedef enum int {FR_GOOD, FR_BAD_CRC, FR_BAD_VER, FR_BAD_LEN, FR_TIMEOUT} t_frame_kind;

    localparam int FILL_LEN = 64;

    logic i_clk = 1'b0;
    logic i_rst_n;

    frx_chan_if #(.t_payload(t_in_item))  in_if  ();
    frx_chan_if #(.t_payload(t_out_item)) out_if ();
    frx_chan_if #(.t_payload(t_cfg_item)) cfg_if ();

    int fail_count;
    int pending;
    int result_count;
    int packet_count;

    logic [7:0]  sof1;
    logic [7:0]  sof2;
    logic [7:0]  ver;
    logic [31:0] tmo;
    logic [10:0] maxlen;
    logic [31:0] stamp;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          item_cnt;
    bit          reads_ok;
    bit          resync_needed;

    frame_receiver_crc32_timeout_top #(.PAYLOAD_DEPTH(1024)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    frx_frame_checker u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_if.valid),
        .i_in_ready     (in_if.ready),
        .i_in_data      (in_if.data),
        .i_out_valid    (out_if.valid),
        .i_out_ready    (out_if.ready),
        .i_out_data     (out_if.data),
        .i_cfg_valid    (cfg_if.valid),
        .i_cfg_ready    (cfg_if.ready),
        .i_cfg_data     (cfg_if.data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_packet_count (packet_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ b[k]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [31:0] normal_gap();
        if ($urandom_range(19) == 0) return tmo;
        return $urandom_range(0, (tmo < 32'd20) ? tmo : 32'd20);
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] b, input logic [31:0] now,
                             input logic [9:0] ridx);
        t_in_item it;
        it.command    = cmd;
        it.data_byte  = b;
        it.now_ms     = now;
        it.read_index = ridx;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        item_cnt++;
    endtask

    task automatic consume_byte(input logic [7:0] b, input logic [31:0] delta);
        if (reads_ok && $urandom_range(9) == 0) begin
            send_item(CMD_READ, 8'($urandom()), $urandom(),
                      10'($urandom_range(0, FILL_LEN - 1)));
        end
        stamp = stamp + delta;
        send_item(CMD_CONSUME, b, stamp, 10'($urandom()));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        t_cfg_item c;
        c.index = idx;
        c.value = val;
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= c;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_START_FIRST:  sof1   = val[7:0];
            CFG_START_SECOND: sof2   = val[7:0];
            CFG_VERSION:      ver    = val[7:0];
            CFG_TIMEOUT:      tmo    = val;
            CFG_MAX_LEN:      maxlen = val[10:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] v,
                             input logic [31:0] t, input logic [10:0] m);
        wait_idle();
        write_reg(CFG_START_FIRST, {24'd0, s1});
        write_reg(CFG_START_SECOND, {24'd0, s2});
        write_reg(CFG_VERSION, {24'd0, v});
        write_reg(CFG_TIMEOUT, t);
        write_reg(CFG_MAX_LEN, {21'd0, m});
        resync_needed = 1'b1;
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
        endcase
    endtask

    task automatic send_frame(input t_frame_kind kind, input int len);
        logic [7:0]  fb [$];
        logic [31:0] crc;
        logic [15:0] hlen;
        logic [31:0] delta;
        logic [7:0]  pb;
        int          cut;
        hlen = 16'(len);
        fb.push_back(sof1);
        fb.push_back(sof2);
        fb.push_back((kind == FR_BAD_VER) ? (ver ^ (8'h01 << $urandom_range(7))) : ver);
        fb.push_back(8'($urandom()));
        fb.push_back(8'($urandom()));
        fb.push_back(8'($urandom()));
        fb.push_back(hlen[7:0]);
        fb.push_back(hlen[15:8]);
        crc = CRC_INIT;
        for (int k = 2; k < 8; k++) crc = crc32_next(crc, fb[k]);
        if (kind != FR_BAD_LEN) begin
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(5))
                    0:       pb = 8'h00;
                    1:       pb = 8'hFF;
                    default: pb = 8'($urandom());
                endcase
                fb.push_back(pb);
                crc = crc32_next(crc, pb);
            end
            crc = crc ^ 32'hFFFF_FFFF;
            if (kind == FR_BAD_CRC) crc = crc ^ (32'd1 << $urandom_range(31));
            for (int k = 0; k < 4; k++) fb.push_back(crc[8*k +: 8]);
        end
        cut = (kind == FR_TIMEOUT) ? $urandom_range(1, fb.size() - 1) : -1;
        for (int k = 0; k < fb.size(); k++) begin
            if (k == cut) begin
                delta = tmo + 32'd1 + $urandom_range(0, 255);
            end else if (k == 0 && resync_needed && tmo <= 32'hFFFF_F000) begin
                delta = tmo + 32'd1;
            end else begin
                delta = normal_gap();
            end
            consume_byte(fb[k], delta);
        end
        resync_needed = (kind == FR_TIMEOUT);
    endtask

    task automatic noise_burst();
        int          n;
        logic [7:0]  b;
        logic [31:0] delta;
        n = $urandom_range(1, 8);
        repeat (n) begin
            case ($urandom_range(3))
                0:       b = sof1;
                1:       b = sof2;
                default: b = 8'($urandom());
            endcase
            delta = ($urandom_range(3) == 0) ? $urandom() : normal_gap();
            consume_byte(b, delta);
        end
        resync_needed = 1'b1;
    endtask

    task automatic run_segment(input int n_items);
        int start;
        int pick;
        int lmax;
        int len;
        start = item_cnt;
        while (item_cnt - start < n_items) begin
            pick = $urandom_range(99);
            lmax = (maxlen > 11'd24) ? 24 : int'(maxlen);
            len  = $urandom_range(0, lmax);
            if (maxlen <= 11'd64 && $urandom_range(49) == 0) len = int'(maxlen);
            if (pick < 8) begin
                noise_burst();
            end else if (pick < 16) begin
                send_frame(FR_BAD_CRC, len);
            end else if (pick < 23) begin
                send_frame(FR_BAD_VER, len);
            end else if (pick < 30) begin
                if ($urandom_range(1) == 0) begin
                    send_frame(FR_BAD_LEN, int'(maxlen) + 1);
                end else begin
                    send_frame(FR_BAD_LEN, $urandom_range(int'(maxlen) + 1, 65535));
                end
            end else if (pick < 37 && tmo <= 32'hFFFF_F000) begin
                send_frame(FR_TIMEOUT, len);
            end else begin
                send_frame(FR_GOOD, len);
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.data    = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        item_cnt      = 0;
        reads_ok      = 1'b0;
        resync_needed = 1'b0;
        stamp         = '0;
        sof1          = '0;
        sof2          = '0;
        ver           = '0;
        tmo           = TIMEOUT_RESET;
        maxlen        = MAX_LEN_RESET;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill the low payload entries so every later read hits written data
        configure(8'hA5, 8'h5A, 8'h01, 32'd1000, 11'd1024);
        resync_needed = 1'b0;
        send_frame(FR_GOOD, FILL_LEN);
        reads_ok = 1'b1;

        send_item(CMD_READ, 8'h00, 32'h0000_0000, 10'd0);
        send_item(CMD_READ, 8'hFF, 32'hFFFF_FFFF, 10'(FILL_LEN - 1));
        send_frame(FR_GOOD, 0);
        send_frame(FR_BAD_LEN, 65535);
        send_frame(FR_TIMEOUT, 0);
        // second start byte wrong: search restarts on that byte
        consume_byte(sof1, 32'd1);
        consume_byte(sof2 ^ 8'h01, 32'd1);
        resync_needed = 1'b1;

        for (int s = 0; s < 8; s++) begin
            case (s % 4)
                0: configure(8'hA5, 8'h5A, 8'h01, 32'd1000, 11'd1024);
                1: configure(8'h00, 8'hFF, 8'hFF, 32'd0, 11'd0);
                2: configure(8'hFF, 8'hFF, 8'h00, 32'hFFFF_FFFF, 11'd16);
                default: begin
                    configure(8'($urandom()), 8'($urandom()), 8'($urandom()),
                              $urandom_range(1, 50), 11'($urandom_range(1, 64)));
                    stamp = $urandom() | 32'hFFFF_F000;
                end
            endcase
            set_idle(s / 2);
            run_segment(50);
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        $display("Run covered %0d input transfers and %0d results, %0d of them delivered frames,",
                 item_cnt, result_count, packet_count);
        $display("over five register settings and four back-pressure patterns.");
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
